/* sv/bsem_pkg.sv */
// Shared types and constants for the boxcar smoother / extremum marker.
// Holds the command word passed from the front end to the back end through the queue.
// No dependencies.
package bsem_pkg;

    localparam int SAMPLE_W    = 16;   // width of the sample field on the input stream
    localparam int POSITION_W  = 12;   // width of the position field on the output stream
    localparam int SMOOTHED_W  = 16;   // width of the smoothed field on the output stream

    localparam int CNT_W       = 5;    // holds item counts and chain offsets up to 31
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Per-sample command: what the back end has to do with one queue entry
    typedef struct packed {
        logic             avg;      // window full, smoothed value is the mean
        logic             upd;      // shift prev/cur smoothed values
        logic             seq_end;  // final sample, flush and restart
        logic [CNT_W-1:0] skip;     // leading chain entries to drop before emitting
        logic [CNT_W-1:0] count;    // output items caused by this sample
    } bsem_cmd_t;

endpackage

/* sv/bsem_queue.sv */
// Small register FIFO between the front and back ends.
// Generic width and depth; no package dependency.
module bsem_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == '0);
    assign count    = count_reg;

endmodule

/* sv/bsem_front.sv */
// Front end: takes samples, keeps the sample window and running sum, classifies each
// sample into a command and computes the window mean (reciprocal multiply). Uses bsem_pkg.
module bsem_front #(
    parameter int HALF_WINDOW = 5,
    parameter int SW          = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SW-1:0]                 in_sample,
    input  logic                          in_end,
    input  logic [bsem_pkg::QCNT_W-1:0]   q_count,
    output logic                          push,
    output logic [$bits(bsem_pkg::bsem_cmd_t)+SW*(HALF_WINDOW+1)-1:0] push_data
);

    localparam int WIN    = 2 * HALF_WINDOW + 1;
    localparam int RING   = WIN + 1;
    localparam int SEEN_W = $clog2(RING + 1);
    localparam int SUM_W  = SW + $clog2(WIN);
    localparam int PROD_W = 2 * SUM_W;
    localparam int SNAP   = HALF_WINDOW + 1;
    localparam int CW     = bsem_pkg::CNT_W;
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((64'd1 << SUM_W) / WIN);

    logic [SW-1:0]     ring_reg [WIN];
    logic [SW-1:0]     ring_next [WIN];
    logic [SW-1:0]     shifted [WIN];
    logic [SUM_W-1:0]  sum_reg, sum_next, sum_upd;
    logic [SEEN_W-1:0] seen_reg, seen_next, seen_inc;
    logic              accept;
    logic [bsem_pkg::QCNT_W:0] credit;
    bsem_pkg::bsem_cmd_t cmd;
    logic [CW-1:0]     fill, head;

    // stage 1: updated sum and window snapshot
    logic                s1_valid_reg;
    bsem_pkg::bsem_cmd_t s1_cmd_reg;
    logic [SUM_W-1:0]    s1_sum_reg;
    logic [SW-1:0]       s1_snap_reg [SNAP];
    // stage 2: sum times reciprocal
    logic                s2_valid_reg;
    bsem_pkg::bsem_cmd_t s2_cmd_reg;
    logic [SUM_W-1:0]    s2_sum_reg;
    logic [PROD_W-1:0]   s2_prod_reg;
    logic [SW-1:0]       s2_snap_reg [SNAP];

    logic [SUM_W-1:0]    quot_est, quot, rem;
    logic [SW-1:0]       next_val;
    logic [SW*HALF_WINDOW-1:0] tail;

    // Credit check: the queue must have room for everything still in the pipe
    always_comb
    begin
        credit = {1'b0, q_count}
               + (bsem_pkg::QCNT_W+1)'(s1_valid_reg)
               + (bsem_pkg::QCNT_W+1)'(s2_valid_reg);
        in_ready = (credit < (bsem_pkg::QCNT_W+1)'(bsem_pkg::QUEUE_DEPTH));
    end

    assign accept = in_valid && in_ready;

    always_comb
    begin
        sum_upd  = sum_reg + SUM_W'(in_sample) - SUM_W'(ring_reg[WIN-1]);
        seen_inc = (seen_reg < SEEN_W'(RING)) ? seen_reg + 1'b1 : seen_reg;
        shifted[0] = in_sample;
        for (int i = 1; i < WIN; i++)
            shifted[i] = ring_reg[i-1];

        ring_next = ring_reg;
        sum_next  = sum_reg;
        seen_next = seen_reg;
        if (accept)
        begin
            if (in_end)
            begin
                for (int i = 0; i < WIN; i++)
                    ring_next[i] = '0;
                sum_next  = '0;
                seen_next = '0;
            end
            else
            begin
                ring_next = shifted;
                sum_next  = sum_upd;
                seen_next = seen_inc;
            end
        end

        // classification by how many samples of this sequence are in
        fill = (seen_inc < SEEN_W'(HALF_WINDOW + 1)) ? CW'(seen_inc) : CW'(HALF_WINDOW + 1);
        head = (seen_inc < SEEN_W'(HALF_WINDOW + 2)) ? CW'(seen_inc) : CW'(HALF_WINDOW + 2);
        cmd.avg     = (seen_inc >= SEEN_W'(WIN));
        cmd.upd     = (seen_inc >= SEEN_W'(HALF_WINDOW + 1));
        cmd.seq_end = in_end;
        cmd.count   = CW'(seen_inc >= SEEN_W'(HALF_WINDOW + 2)) + (in_end ? fill : '0);
        cmd.skip    = in_end ? CW'(HALF_WINDOW + 2) - head : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WIN; i++)
                ring_reg[i] <= '0;
            sum_reg      <= '0;
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            ring_reg     <= ring_next;
            sum_reg      <= sum_next;
            seen_reg     <= seen_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg <= cmd;
            s1_sum_reg <= sum_upd;
            for (int i = 0; i < SNAP; i++)
                s1_snap_reg[i] <= shifted[i];
        end
        s2_cmd_reg  <= s1_cmd_reg;
        s2_sum_reg  <= s1_sum_reg;
        s2_prod_reg <= PROD_W'(s1_sum_reg) * PROD_W'(RECIP);
        s2_snap_reg <= s1_snap_reg;
    end

    // Reciprocal estimate is low by at most one; one compare fixes it
    always_comb
    begin
        quot_est = s2_prod_reg[PROD_W-1 -: SUM_W];
        rem      = s2_sum_reg - SUM_W'(quot_est * SUM_W'(WIN));
        quot     = (rem >= SUM_W'(WIN)) ? quot_est + 1'b1 : quot_est;
        next_val = s2_cmd_reg.avg ? quot[SW-1:0] : s2_snap_reg[HALF_WINDOW];
        for (int i = 0; i < HALF_WINDOW; i++)
            tail[i*SW +: SW] = s2_snap_reg[i];
    end

    assign push      = s2_valid_reg;
    assign push_data = {s2_cmd_reg, next_val, tail};

endmodule

/* sv/bsem_back.sv */
// Back end: pops commands, builds the chain of smoothed points and emits, unless stalled,
// one output item per cycle with peak/valley flags into an output register. Uses bsem_pkg.
module bsem_back #(
    parameter int HALF_WINDOW = 5,
    parameter int SW          = 16,
    parameter int MAX_LEN     = 4096
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_empty,
    input  logic [$bits(bsem_pkg::bsem_cmd_t)+SW*(HALF_WINDOW+1)-1:0] q_data,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [bsem_pkg::POSITION_W-1:0]       out_position,
    output logic [bsem_pkg::SMOOTHED_W-1:0]       out_smoothed,
    output logic                                  out_peak,
    output logic                                  out_valley,
    output logic                                  out_last
);

    localparam int CMD_W   = $bits(bsem_pkg::bsem_cmd_t);
    localparam int ENTRY_W = CMD_W + SW * (HALF_WINDOW + 1);
    localparam int CHAIN_N = HALF_WINDOW + 3;
    localparam int CHAIN_W = CHAIN_N * SW;
    localparam int POS_W   = $clog2(MAX_LEN);
    localparam int CW      = bsem_pkg::CNT_W;

    bsem_pkg::bsem_cmd_t       cmd;
    logic [SW-1:0]             q_next;
    logic [SW*HALF_WINDOW-1:0] q_tail;
    logic [CHAIN_W-1:0]        c_vec, chain_load;

    logic [CHAIN_W-1:0] chain_reg, chain_next;
    logic [CW-1:0]      rem_reg, rem_next;
    logic               end_reg, end_next;
    logic [SW-1:0]      prev_reg, prev_next;
    logic [SW-1:0]      cur_reg, cur_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               started_reg, started_next;
    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   out_pos_reg;
    logic [SW-1:0]      out_val_reg;
    logic               out_peak_reg, out_valley_reg, out_last_reg;

    logic               emit_fire, last, flaggable;
    logic [SW-1:0]      v, pv, nv;

    always_comb
    begin
        cmd    = q_data[ENTRY_W-1 -: CMD_W];
        q_next = q_data[SW*HALF_WINDOW +: SW];
        q_tail = q_data[SW*HALF_WINDOW-1:0];

        // chain: prev, cur, next, then raw samples oldest first
        c_vec = '0;
        c_vec[0 +: SW]    = prev_reg;
        c_vec[SW +: SW]   = cur_reg;
        c_vec[2*SW +: SW] = q_next;
        for (int j = 0; j < HALF_WINDOW; j++)
            c_vec[(HALF_WINDOW + 2 - j)*SW +: SW] = q_tail[j*SW +: SW];
        chain_load = c_vec >> (SW * int'(cmd.skip));
    end

    always_comb
    begin
        v  = chain_reg[SW +: SW];
        pv = chain_reg[0 +: SW];
        nv = chain_reg[2*SW +: SW];

        emit_fire = (rem_reg != '0) && (!out_valid_reg || out_ready);
        last      = end_reg && (rem_reg == CW'(1));
        flaggable = started_reg && !last;
        q_pop     = !q_empty && ((rem_reg == '0) || ((rem_reg == CW'(1)) && emit_fire));

        chain_next = chain_reg;
        rem_next   = rem_reg;
        end_next   = end_reg;
        prev_next  = prev_reg;
        cur_next   = cur_reg;
        if (q_pop)
        begin
            chain_next = chain_load;
            rem_next   = cmd.count;
            end_next   = cmd.seq_end;
            if (cmd.seq_end)
            begin
                prev_next = '0;
                cur_next  = '0;
            end
            else if (cmd.upd)
            begin
                prev_next = cur_reg;
                cur_next  = q_next;
            end
        end
        else if (emit_fire)
        begin
            chain_next = chain_reg >> SW;
            rem_next   = rem_reg - 1'b1;
        end

        pos_next       = pos_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            if (last)
            begin
                pos_next     = '0;
                started_next = 1'b0;
            end
            else
            begin
                pos_next     = (pos_reg == POS_W'(MAX_LEN - 1)) ? '0 : pos_reg + 1'b1;
                started_next = 1'b1;
            end
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= '0;
            end_reg       <= 1'b0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            pos_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            end_reg       <= end_next;
            prev_reg      <= prev_next;
            cur_reg       <= cur_next;
            pos_reg       <= pos_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chain_reg <= chain_next;
        if (emit_fire)
        begin
            out_pos_reg    <= pos_reg;
            out_val_reg    <= v;
            out_peak_reg   <= flaggable && (v > pv) && (v > nv);
            out_valley_reg <= flaggable && (v < pv) && (v < nv);
            out_last_reg   <= last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_position = bsem_pkg::POSITION_W'(out_pos_reg);
    assign out_smoothed = bsem_pkg::SMOOTHED_W'(out_val_reg);
    assign out_peak     = out_peak_reg;
    assign out_valley   = out_valley_reg;
    assign out_last     = out_last_reg;

endmodule

/* sv/boxcar_smoother_extremum_marker.sv */
// Top level of the boxcar smoother with peak/valley marking.
// Instantiates bsem_front, bsem_queue and bsem_back; uses bsem_pkg.
//
// Accepts one sample per clock while the queue has room and sustains one output item
// per clock while m_axis_tready is high. Each sample with HALF_WINDOW neighbors on both
// sides comes out as the truncated mean of the 2*HALF_WINDOW+1 centered samples; edge
// samples come out raw. The item for position n is released by sample n+HALF_WINDOW+1
// and passes the two-stage reciprocal-multiply divider, queue and output register. The
// sample marked tlast releases its own item plus the remaining HALF_WINDOW+1 (or fewer,
// for a short run) items, one per cycle from the back end while the output is not
// stalled; input keeps flowing meanwhile until the four-entry command queue fills. The
// last item of a run carries tlast, and the next sample starts a new run at position 0.
module boxcar_smoother_extremum_marker #(
    parameter int HALF_WINDOW = 5,
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_LEN     = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tlast,   // seq_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [11:0] position, [27:12] smoothed, zero pad
    output logic [1:0]  m_axis_tuser,   // [0] is_peak, [1] is_valley
    output logic        m_axis_tlast    // run_end
);

    localparam int SW      = (SAMPLE_BITS < bsem_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                                : bsem_pkg::SAMPLE_W;
    localparam int ENTRY_W = $bits(bsem_pkg::bsem_cmd_t) + SW * (HALF_WINDOW + 1);

    logic                              push, pop, q_empty;
    logic [ENTRY_W-1:0]                push_data, pop_data;
    logic [bsem_pkg::QCNT_W-1:0]       q_count;
    logic [bsem_pkg::POSITION_W-1:0]   position;
    logic [bsem_pkg::SMOOTHED_W-1:0]   smoothed;
    logic                              is_peak, is_valley;

    bsem_front #(
        .HALF_WINDOW (HALF_WINDOW),
        .SW          (SW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_sample (s_axis_tdata[SW-1:0]),
        .in_end    (s_axis_tlast),
        .q_count   (q_count),
        .push      (push),
        .push_data (push_data)
    );

    bsem_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (bsem_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty),
        .count     (q_count)
    );

    bsem_back #(
        .HALF_WINDOW (HALF_WINDOW),
        .SW          (SW),
        .MAX_LEN     (MAX_LEN)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (pop_data),
        .q_pop        (pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_position (position),
        .out_smoothed (smoothed),
        .out_peak     (is_peak),
        .out_valley   (is_valley),
        .out_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, smoothed, position};
    assign m_axis_tuser = {is_valley, is_peak};

endmodule

/* bench/tb_boxcar_smoother_extremum_marker.sv */
// Self-checking bench for boxcar_smoother_extremum_marker: random and directed sample runs,
// with a scoreboard that predicts the smoothed points and their peak/valley flags.
// Depends on bsem_pkg and the boxcar_smoother_extremum_marker RTL.
module tb_boxcar_smoother_extremum_marker;

    localparam int SAMPLE_W     = bsem_pkg::SAMPLE_W;
    localparam int POSITION_W   = bsem_pkg::POSITION_W;
    localparam int SMOOTHED_W   = bsem_pkg::SMOOTHED_W;
    localparam int HALF         = 5;
    localparam int WIN          = 2 * HALF + 1;
    localparam int RING         = 2 * HALF + 2;
    localparam int RANDOM_ITEMS = 335;
    localparam int TAIL_CYCLES  = 20;
    localparam int STALL_LIMIT  = 2000;
    localparam int IDLE_PCT     = 12;

    typedef struct {
        logic [POSITION_W-1:0] position;
        logic [SMOOTHED_W-1:0] smoothed;
        logic                  peak;
        logic                  valley;
        logic                  run_end;
    } point_t;

    // Tracks the smoother state and holds the points still owed by the block
    class extremum_scoreboard;
        logic [SAMPLE_W-1:0]   ring [RING];
        int unsigned           window_sum;
        int unsigned           seen;
        logic [POSITION_W-1:0] out_pos;
        logic [SMOOTHED_W-1:0] prev_val;
        logic [SMOOTHED_W-1:0] cur_val;
        point_t                owed_points [$];
        int                    mismatches;

        function new();
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            foreach (ring[i])
                ring[i] = '0;
            window_sum = 0;
            seen       = 0;
            out_pos    = '0;
            prev_val   = '0;
            cur_val    = '0;
        endfunction

        function void push_point(input logic [SMOOTHED_W-1:0] v, pv, nv,
                                 input bit flaggable, run_end);
            point_t p;
            p.position = out_pos;
            p.smoothed = v;
            p.peak     = flaggable && v > pv && v > nv;
            p.valley   = flaggable && v < pv && v < nv;
            p.run_end  = run_end;
            owed_points = {owed_points, p};
            out_pos++;
        endfunction

        // Called for every accepted sample
        function void take_sample(input logic [SAMPLE_W-1:0] x, input logic seq_end);
            logic [SMOOTHED_W-1:0] nxt;
            logic [SMOOTHED_W-1:0] vals [HALF+1];
            logic [SMOOTHED_W-1:0] pv;
            logic [SMOOTHED_W-1:0] nv;
            int                    cnt;
            window_sum = window_sum + x - ring[WIN-1];
            for (int a = RING - 1; a > 0; a--)
                ring[a] = ring[a-1];
            ring[0] = x;
            if (seen < RING)
                seen++;
            if (seen >= HALF + 1)
            begin
                nxt = (seen >= WIN) ? SMOOTHED_W'(window_sum / WIN) : ring[HALF];
                // the very first point of a run is never flagged
                if (seen >= HALF + 2)
                    push_point(cur_val, prev_val, nxt, seen != HALF + 2, 1'b0);
                prev_val = cur_val;
                cur_val  = nxt;
            end
            if (seq_end)
            begin
                cnt = (seen < HALF + 1) ? int'(seen) : HALF + 1;
                for (int k = 0; k < cnt; k++)
                    vals[k] = (k == 0 && seen >= HALF + 1) ? cur_val : ring[cnt-1-k];
                for (int k = 0; k < cnt; k++)
                begin
                    pv = (k == 0) ? prev_val : vals[k-1];
                    nv = (k == cnt - 1) ? '0 : vals[k+1];
                    push_point(vals[k], pv, nv,
                               !(k == 0 && seen == cnt) && k != cnt - 1, k == cnt - 1);
                end
                clear();
            end
        endfunction

        function void note_mismatch(input string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        // Called for every accepted output item
        function void check_point(input logic [31:0] tdata, input logic [1:0] tuser,
                                  input logic tlast);
            point_t                want;
            logic [POSITION_W-1:0] got_pos;
            logic [SMOOTHED_W-1:0] got_val;
            got_pos = tdata[POSITION_W-1:0];
            got_val = tdata[POSITION_W+SMOOTHED_W-1:POSITION_W];
            if (owed_points.size() == 0)
            begin
                note_mismatch($sformatf("unexpected pos %0d val %0d pk %0b vl %0b end %0b",
                                        got_pos, got_val, tuser[0], tuser[1], tlast));
                return;
            end
            want = owed_points.pop_front();
            if (got_pos !== want.position || got_val !== want.smoothed
                || tuser[0] !== want.peak || tuser[1] !== want.valley
                || tlast !== want.run_end || tdata[31:POSITION_W+SMOOTHED_W] !== '0)
                note_mismatch($sformatf(
                    "exp %0d %0d %0b %0b %0b / got %0d %0d %0b %0b %0b pad %h",
                    want.position, want.smoothed, want.peak, want.valley, want.run_end,
                    got_pos, got_val, tuser[0], tuser[1], tlast,
                    tdata[31:POSITION_W+SMOOTHED_W]));
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    extremum_scoreboard sb;
    bit                 no_gaps      = 1'b0;
    int                 quiet_cycles = 0;

    boxcar_smoother_extremum_marker #(
        .HALF_WINDOW (HALF),
        .SAMPLE_BITS (16),
        .MAX_LEN     (4096)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Output side: check accepted items, stall at random
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_point(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_item(input logic [15:0] s, input logic seq_end);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        s_axis_tlast  <= seq_end;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.take_sample(s, seq_end);
    endtask

    task automatic send_run(input logic [15:0] vals [$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    // Hold the input until every owed point has come out, then let the pipe settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.owed_points.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    // Styles: white noise, flat with tiny jitter (ties), random walk, flat with spikes
    function automatic logic [15:0] make_sample(input int style, inout int level);
        case (style)
            0: return 16'($urandom);
            1: return 16'(level + $urandom_range(3));
            2:
            begin
                level = level + int'($urandom_range(4000)) - 2000;
                if (level < 0)
                    level = 0;
                if (level > 65535)
                    level = 65535;
                return 16'(level);
            end
            default: return ($urandom_range(9) == 0) ? 16'($urandom) : 16'(level);
        endcase
    endfunction

    task automatic run_directed();
        logic [15:0] vals [$];
        vals = '{16'hFFFF};                         // single sample
        send_run(vals);
        vals = '{16'h0000, 16'hFFFF};
        send_run(vals);
        vals = '{16'h0000, 16'hFFFF, 16'h0000};     // short run, middle peak
        send_run(vals);
        vals = '{16'h8000, 16'h0001, 16'hFFFE, 16'h7FFF, 16'hFFFF, 16'h0000};
        send_run(vals);
        // just past the window: averaging, then a peak among the raw end-of-run points
        vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000};
        send_run(vals);
    endtask

    task automatic run_random();
        int sent;
        int len;
        int style;
        int level;
        int pick;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                len = $urandom_range(1, WIN);
            else if (pick < 85)
                len = $urandom_range(WIN + 1, 40);
            else
                len = $urandom_range(41, 90);
            if (len > RANDOM_ITEMS - sent)
                len = RANDOM_ITEMS - sent;
            style   = $urandom_range(3);
            level   = $urandom_range(65532);
            no_gaps = (sent >= 140 && sent < 230);
            for (int i = 0; i < len; i++)
                send_item(make_sample(style, level), i == len - 1);
            sent += len;
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        wait_drained();
        run_random();
        wait_drained();
        if (sb.mismatches == 0 && sb.owed_points.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
sv/bsem_pkg.sv
sv/bsem_queue.sv
sv/bsem_front.sv
sv/bsem_back.sv
sv/boxcar_smoother_extremum_marker.sv
bench/tb_boxcar_smoother_extremum_marker.sv
